// ===== src/pdh_pkg.sv =====
// Package for the point distance and heading block: widths, pipeline depths,
// opcode codes, stage structs and the elaboration-time constant functions.
// No dependencies.
package pdh_pkg;

  localparam int COORD_W    = 32;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int MAG_W      = COORD_W;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int SUM_W      = SQ_W + 2;
  localparam int ROOT_W     = SUM_W / 2 + 1;
  localparam int REM_W      = ROOT_W + 3;
  localparam int DIST_W     = 33;
  localparam int HEAD_W     = 24;

  localparam int CORD_W       = 64;
  localparam int NORM_STEPS   = 6;
  localparam int NORM_TOP     = 59;
  localparam int CORDIC_STEPS = 32;
  localparam int C_W          = 61;
  localparam int K_W          = 54;
  localparam int C_LO_W       = 31;
  localparam int K_LO_W       = 27;
  localparam int PROD_W       = C_W + K_W + 1;
  localparam int ANG_SHIFT    = 60;
  localparam int ANG_W        = PROD_W - ANG_SHIFT;
  localparam int H_W          = 58;

  localparam int FRONT_LAT = 4;
  localparam int SQRT_LAT  = ROOT_W + 1;
  localparam int ANG_LAT   = NORM_STEPS + CORDIC_STEPS + 4;
  localparam int DIST_DLY  = ANG_LAT - SQRT_LAT;

  localparam logic [H_W-1:0] HALF_PI_ANG = H_W'(65535) << 38;
  localparam logic [H_W-1:0] ORIGIN_ANG  = H_W'(1) << 55;
  localparam logic [H_W-1:0] ROUND_ANG   = H_W'(1) << 31;

  typedef enum logic [1:0] {
    OP_PLANAR  = 2'd0,
    OP_SPATIAL = 2'd1,
    OP_HEADING = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t op;
    logic    degen;
  } tag_t;

  typedef struct packed {
    logic               valid;
    tag_t               tag;
    logic [SUM_W-1:0]   sum;
    logic [MAG_W-1:0]   major;
    logic [MAG_W-1:0]   minor;
    logic               swap;
    logic               base;
    logic               dxpos;
  } front_t;

  typedef struct packed {
    tag_t tag;
    logic swap;
    logic base;
    logic dxpos;
  } side_t;

  // atan(2^-i) in Q60 radians, as a truncated alternating series.
  function automatic logic [63:0] atan_q60(input int i);
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] t;
    logic [63:0] r;
    logic [63:0] d;
    int          e;
    pos = '0;
    neg = '0;
    for (int k = 0; k < 31; k++) begin
      e = 60 - i * (2 * k + 1);
      if (e >= 0) begin
        d = 64'(2 * k + 1);
        r = '0;
        t = '0;
        for (int b = 60; b >= 0; b--) begin
          r = {r[62:0], (b == e)};
          if (r >= d) begin
            r    = r - d;
            t[b] = 1'b1;
          end
        end
        if (k[0]) neg = neg + t;
        else pos = pos + t;
      end
    end
    return pos - neg;
  endfunction

  // Heading LSBs per radian with 32 fraction bits, truncated.
  function automatic logic [K_W-1:0] lsb_per_radian();
    logic [53:0] n;
    logic [35:0] d;
    logic [35:0] r;
    logic [85:0] q;
    logic        nb;
    n = 54'd16776960000000000;
    d = 36'd6283185307;
    r = '0;
    q = '0;
    for (int b = 85; b >= 0; b--) begin
      if (b >= 32) nb = n[b-32];
      else nb = 1'b0;
      r = {r[34:0], nb};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q[K_W-1:0];
  endfunction

endpackage

// ===== src/point_distance_and_heading.sv =====
// Point distance and heading: one result item per accepted item, one item per
// cycle sustained; busy stays low. The depth is set by the heading path: a
// 4-stage front end, a 6-stage normalizer, the 32-stage CORDIC, 4 stages of
// multiply and assembly and the output register; the 35-stage square root runs
// beside it. rst clears only the valid chain. Depends on pdh_pkg, pdh_front,
// pdh_sqrt, pdh_angle.
module point_distance_and_heading import pdh_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          opcode,
  input  logic signed [31:0]  pos_x,
  input  logic signed [31:0]  pos_y,
  input  logic signed [31:0]  pos_z,
  input  logic signed [31:0]  tar_x,
  input  logic signed [31:0]  tar_y,
  input  logic signed [31:0]  tar_z,
  output logic                done,
  output logic [DIST_W-1:0]   distance,
  output logic [HEAD_W-1:0]   heading,
  output logic                degenerate
);

  front_t              front;
  side_t               side;
  logic                sq_valid;
  logic [DIST_W-1:0]   sq_root;
  logic                an_valid;
  tag_t                an_tag;
  logic [HEAD_W-1:0]   an_heading;
  logic [DIST_W-1:0]   dist_d [0:DIST_DLY];

  assign busy = 1'b0;

  pdh_front u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .opcode(opcode),
    .pos_x (pos_x),
    .pos_y (pos_y),
    .pos_z (pos_z),
    .tar_x (tar_x),
    .tar_y (tar_y),
    .tar_z (tar_z),
    .front (front)
  );

  pdh_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (front.valid),
    .in_sum   (front.sum),
    .out_valid(sq_valid),
    .out_root (sq_root)
  );

  assign side.tag   = front.tag;
  assign side.swap  = front.swap;
  assign side.base  = front.base;
  assign side.dxpos = front.dxpos;

  pdh_angle u_angle (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (front.valid),
    .in_major   (front.major),
    .in_minor   (front.minor),
    .in_side    (side),
    .out_valid  (an_valid),
    .out_tag    (an_tag),
    .out_heading(an_heading)
  );

  // The root is ready before the heading; hold it back to line up.
  assign dist_d[0] = sq_root;
  for (genvar d = 0; d < DIST_DLY; d++) begin : g_dly
    always_ff @(posedge clk) begin
      dist_d[d+1] <= dist_d[d];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= an_valid;
  end

  always_ff @(posedge clk) begin
    distance   <= (an_tag.op == OP_NONE) ? '0 : dist_d[DIST_DLY];
    degenerate <= (an_tag.op != OP_NONE) && an_tag.degen;
    heading    <= (an_tag.op == OP_HEADING && !an_tag.degen) ? an_heading : '0;
  end

endmodule

// ===== src/pdh_front.sv =====
// Front end of the point distance and heading pipeline: differences,
// magnitudes, squares, sum of squares and the angle operand selection.
// Depends on pdh_pkg.
module pdh_front import pdh_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [1:0]          opcode,
  input  logic signed [31:0]  pos_x,
  input  logic signed [31:0]  pos_y,
  input  logic signed [31:0]  pos_z,
  input  logic signed [31:0]  tar_x,
  input  logic signed [31:0]  tar_y,
  input  logic signed [31:0]  tar_z,
  output front_t              front
);

  logic                     v1, v2, v3;
  opcode_t                  op1, op2, op3;
  logic signed [DIFF_W-1:0] dx1, dy1, dz1;
  logic [MAG_W-1:0]         mx2, my2, mz2;
  logic                     dxpos2, dzneg2, dxpos3, base3;
  logic [SQ_W-1:0]          sx3, sy3, sz3;
  logic [MAG_W-1:0]         a3, b3;
  logic [SUM_W-1:0]         sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      front.valid <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
      front.valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    op1 <= opcode_t'(opcode);
    dx1 <= DIFF_W'(tar_x) - DIFF_W'(pos_x);
    dy1 <= DIFF_W'(tar_y) - DIFF_W'(pos_y);
    dz1 <= DIFF_W'(tar_z) - DIFF_W'(pos_z);
  end

  always_ff @(posedge clk) begin
    op2    <= op1;
    mx2    <= dx1[DIFF_W-1] ? MAG_W'(-dx1) : MAG_W'(dx1);
    my2    <= dy1[DIFF_W-1] ? MAG_W'(-dy1) : MAG_W'(dy1);
    mz2    <= dz1[DIFF_W-1] ? MAG_W'(-dz1) : MAG_W'(dz1);
    dxpos2 <= !dx1[DIFF_W-1] && (dx1 != '0);
    dzneg2 <= dz1[DIFF_W-1];
  end

  // The angle is reduced to atan2 of two magnitudes; a negative dz adds a
  // quarter turn and rotates the pair.
  always_ff @(posedge clk) begin
    op3    <= op2;
    sx3    <= mx2 * mx2;
    sy3    <= my2 * my2;
    sz3    <= mz2 * mz2;
    dxpos3 <= dxpos2;
    base3  <= dzneg2;
    a3     <= dzneg2 ? mx2 : mz2;
    b3     <= dzneg2 ? mz2 : mx2;
  end

  always_comb begin
    sum_next = SUM_W'(sx3) + SUM_W'(sz3);
    if (op3 == OP_SPATIAL) sum_next = sum_next + SUM_W'(sy3);
  end

  always_ff @(posedge clk) begin
    front.tag.op    <= op3;
    front.tag.degen <= (sum_next == '0);
    front.sum       <= sum_next;
    front.swap      <= (b3 > a3);
    front.major     <= (b3 > a3) ? b3 : a3;
    front.minor     <= (b3 > a3) ? a3 : b3;
    front.base      <= base3;
    front.dxpos     <= dxpos3;
  end

endmodule

// ===== src/pdh_sqrt.sv =====
// Pipelined digit-by-digit square root with round to nearest, one root bit
// per stage. Depends on pdh_pkg.
module pdh_sqrt import pdh_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [SUM_W-1:0]  in_sum,
  output logic              out_valid,
  output logic [DIST_W-1:0] out_root
);

  // The radicand is widened so that every stage reads a full pair of bits.
  localparam int RAD_W = 2 * ROOT_W;

  logic              v_s [0:ROOT_W];
  logic [RAD_W-1:0]  s_s [0:ROOT_W];
  logic [REM_W-1:0]  r_s [0:ROOT_W];
  logic [ROOT_W-1:0] q_s [0:ROOT_W];

  assign v_s[0] = in_valid;
  assign s_s[0] = RAD_W'(in_sum);
  assign r_s[0] = '0;
  assign q_s[0] = '0;

  for (genvar g = 0; g < ROOT_W; g++) begin : g_bit
    localparam int I = ROOT_W - 1 - g;
    logic [REM_W-1:0] rsh;
    logic [REM_W-1:0] trial;
    logic             ge;

    always_comb begin
      rsh   = {r_s[g][REM_W-3:0], s_s[g][2*I+1 -: 2]};
      trial = REM_W'({q_s[g], 2'b01});
      ge    = (rsh >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) v_s[g+1] <= 1'b0;
      else v_s[g+1] <= v_s[g];
    end

    always_ff @(posedge clk) begin
      s_s[g+1] <= s_s[g];
      r_s[g+1] <= ge ? rsh - trial : rsh;
      q_s[g+1] <= {q_s[g][ROOT_W-2:0], ge};
    end
  end

  // The remainder is sum minus root squared; above the root, round up.
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= v_s[ROOT_W];
  end

  always_ff @(posedge clk) begin
    if (r_s[ROOT_W] > REM_W'(q_s[ROOT_W])) out_root <= DIST_W'(q_s[ROOT_W] + 1'b1);
    else out_root <= DIST_W'(q_s[ROOT_W]);
  end

endmodule

// ===== src/pdh_angle.sv =====
// Heading pipeline: normalizing shifter, 32-stage CORDIC vectoring, split
// constant multiply and quadrant assembly with rounding. Depends on pdh_pkg.
module pdh_angle import pdh_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [MAG_W-1:0]  in_major,
  input  logic [MAG_W-1:0]  in_minor,
  input  side_t             in_side,
  output logic              out_valid,
  output tag_t              out_tag,
  output logic [HEAD_W-1:0] out_heading
);

  localparam logic [K_W-1:0] LSB_PER_RAD = lsb_per_radian();
  localparam int             C_HI_W      = C_W - C_LO_W;
  localparam int             K_HI_W      = K_W - K_LO_W;

  logic              nv [0:NORM_STEPS];
  side_t             ns [0:NORM_STEPS];
  logic [CORD_W-1:0] nx [0:NORM_STEPS];
  logic [CORD_W-1:0] ny [0:NORM_STEPS];

  assign nv[0] = in_valid;
  assign ns[0] = in_side;
  assign nx[0] = CORD_W'(in_major);
  assign ny[0] = CORD_W'(in_minor);

  // Shift the pair left until the larger one reaches bit 59.
  for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
    localparam int SH = 32 >> k;
    logic do_shift;

    assign do_shift = (nx[k][NORM_TOP -: SH] == '0);

    always_ff @(posedge clk) begin
      if (rst) nv[k+1] <= 1'b0;
      else nv[k+1] <= nv[k];
    end

    always_ff @(posedge clk) begin
      ns[k+1] <= ns[k];
      nx[k+1] <= do_shift ? nx[k] << SH : nx[k];
      ny[k+1] <= do_shift ? ny[k] << SH : ny[k];
    end
  end

  logic                     cv [0:CORDIC_STEPS];
  side_t                    cs [0:CORDIC_STEPS];
  logic signed [CORD_W-1:0] cx [0:CORDIC_STEPS];
  logic signed [CORD_W-1:0] cy [0:CORDIC_STEPS];
  logic signed [CORD_W-1:0] cz [0:CORDIC_STEPS];

  assign cv[0] = nv[NORM_STEPS];
  assign cs[0] = ns[NORM_STEPS];
  assign cx[0] = $signed(nx[NORM_STEPS]);
  assign cy[0] = $signed(ny[NORM_STEPS]);
  assign cz[0] = '0;

  for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cordic
    localparam int                 I  = j + 1;
    localparam logic [CORD_W-1:0]  AT = atan_q60(I);

    always_ff @(posedge clk) begin
      if (rst) cv[j+1] <= 1'b0;
      else cv[j+1] <= cv[j];
    end

    always_ff @(posedge clk) begin
      cs[j+1] <= cs[j];
      if (!cy[j][CORD_W-1]) begin
        cx[j+1] <= cx[j] + (cy[j] >>> I);
        cy[j+1] <= cy[j] - (cx[j] >>> I);
        cz[j+1] <= cz[j] + $signed(AT);
      end else begin
        cx[j+1] <= cx[j] - (cy[j] >>> I);
        cy[j+1] <= cy[j] + (cx[j] >>> I);
        cz[j+1] <= cz[j] - $signed(AT);
      end
    end
  end

  // Angle times radians-to-heading constant, cut into four partial products.
  logic [C_W-1:0]                c_clamp;
  logic                          va, vb, vc;
  side_t                         sa, sb, sc;
  logic [C_LO_W+K_LO_W-1:0]      p00;
  logic [C_LO_W+K_HI_W-1:0]      p01;
  logic [C_HI_W+K_LO_W-1:0]      p10;
  logic [C_HI_W+K_HI_W-1:0]      p11;
  logic [PROD_W-1:0]             prod;
  logic [ANG_W-1:0]              ang;
  logic [H_W-1:0]                part;
  logic [H_W-1:0]                mag;
  logic [H_W-1:0]                h;
  logic [H_W-1:0]                h_rnd;

  assign c_clamp = cz[CORDIC_STEPS][CORD_W-1] ? '0 : cz[CORDIC_STEPS][C_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      va        <= cv[CORDIC_STEPS];
      vb        <= va;
      vc        <= vb;
      out_valid <= vc;
    end
  end

  always_ff @(posedge clk) begin
    sa  <= cs[CORDIC_STEPS];
    p00 <= c_clamp[C_LO_W-1:0] * LSB_PER_RAD[K_LO_W-1:0];
    p01 <= c_clamp[C_LO_W-1:0] * LSB_PER_RAD[K_W-1:K_LO_W];
    p10 <= c_clamp[C_W-1:C_LO_W] * LSB_PER_RAD[K_LO_W-1:0];
    p11 <= c_clamp[C_W-1:C_LO_W] * LSB_PER_RAD[K_W-1:K_LO_W];
  end

  assign prod = PROD_W'(p00) + (PROD_W'(p01) << K_LO_W) + (PROD_W'(p10) << C_LO_W)
              + (PROD_W'(p11) << (C_LO_W + K_LO_W));

  always_ff @(posedge clk) begin
    sb  <= sa;
    ang <= prod[PROD_W-1:ANG_SHIFT];
  end

  assign part = sb.swap ? HALF_PI_ANG - H_W'(ang) : H_W'(ang);

  always_ff @(posedge clk) begin
    sc  <= sb;
    mag <= part + (sb.base ? HALF_PI_ANG : '0);
  end

  assign h     = sc.dxpos ? ORIGIN_ANG + mag : ORIGIN_ANG - mag;
  assign h_rnd = h + ROUND_ANG;

  always_ff @(posedge clk) begin
    out_tag     <= sc.tag;
    out_heading <= h_rnd[32 +: HEAD_W];
  end

endmodule

// ===== sim/tb_point_distance_and_heading.sv =====
// Testbench for point_distance_and_heading: drives point pairs through the
// command interface, predicts distance and heading, and checks every result.
// Depends on pdh_pkg and the point_distance_and_heading RTL.
module tb_point_distance_and_heading;
  import pdh_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 47;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    bit [32:0] span;
    bit [23:0] head;
    bit        degen;
  } answer_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [1:0]        opcode;
  logic signed [31:0] pos_x, pos_y, pos_z, tar_x, tar_y, tar_z;
  logic              done;
  logic [DIST_W-1:0] distance;
  logic [HEAD_W-1:0] heading;
  logic              degenerate;

  answer_t pending_answers[$];
  int      error_count;
  int      items_sent;
  int      answers_seen;
  int      burst_left;
  longint  cycle_count;

  point_distance_and_heading dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .tar_x(tar_x), .tar_y(tar_y), .tar_z(tar_z),
    .done(done), .distance(distance), .heading(heading), .degenerate(degenerate)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // atan(2^-i) in Q60 radians from the truncated alternating series.
  function automatic bit [63:0] arctan_step(input int i);
    bit [63:0] plus_sum;
    bit [63:0] minus_sum;
    int        e;
    plus_sum = 0;
    minus_sum = 0;
    for (int k = 0; k < 64; k++) begin
      e = 60 - i * (2 * k + 1);
      if (e < 0) break;
      if (k % 2 == 1) minus_sum += (64'd1 << e) / 64'(2 * k + 1);
      else plus_sum += (64'd1 << e) / 64'(2 * k + 1);
    end
    return plus_sum - minus_sum;
  endfunction

  function automatic bit [63:0] radian_scale();
    bit [63:0] n;
    bit [63:0] d;
    bit [63:0] q;
    bit [63:0] r;
    n = 64'd16776960000000000;
    d = 64'd6283185307;
    q = n / d;
    r = n % d;
    for (int k = 0; k < 32; k++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan2(minor, major) in 2^-32 heading units, minor <= major.
  function automatic bit [63:0] rotate_angle(input bit [63:0] major, input bit [63:0] minor);
    bit [63:0]  x;
    bit [63:0]  y;
    bit [63:0]  xs;
    bit [63:0]  ys;
    bit [63:0]  c;
    bit [127:0] prod;
    longint     z;
    x = major;
    y = minor;
    z = 0;
    if (major == 0) return 0;
    while (x < (64'd1 << 59)) begin
      x = x << 1;
      y = y << 1;
    end
    for (int i = 1; i <= 32; i++) begin
      ys = $signed(y) >>> i;
      xs = x >> i;
      if (!y[63]) begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(arctan_step(i));
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(arctan_step(i));
      end
    end
    c = (z < 0) ? 64'd0 : 64'(z);
    prod = {64'd0, c} * {64'd0, radian_scale()};
    return prod[123:60];
  endfunction

  function automatic answer_t predict_answer(input logic [1:0] op,
      input logic signed [31:0] px, input logic signed [31:0] py,
      input logic signed [31:0] pz, input logic signed [31:0] tx,
      input logic signed [31:0] ty, input logic signed [31:0] tz);
    answer_t    a;
    longint     dx, dy, dz;
    bit [63:0]  mx, my, mz, q, cand, lo_part, hi_part, part, m, h;
    bit [127:0] sum;
    bit [127:0] sqr;
    bit [127:0] rem;
    a.span = 0;
    a.head = 0;
    a.degen = 0;
    dx = longint'(tx) - longint'(px);
    dy = longint'(ty) - longint'(py);
    dz = longint'(tz) - longint'(pz);
    mx = (dx < 0) ? 64'(-dx) : 64'(dx);
    my = (dy < 0) ? 64'(-dy) : 64'(dy);
    mz = (dz < 0) ? 64'(-dz) : 64'(dz);
    if (op == OP_NONE) return a;
    sum = {64'd0, mx} * {64'd0, mx} + {64'd0, mz} * {64'd0, mz};
    if (op == OP_SPATIAL) sum += {64'd0, my} * {64'd0, my};
    q = 0;
    for (int b = 33; b >= 0; b--) begin
      cand = q | (64'd1 << b);
      sqr = {64'd0, cand} * {64'd0, cand};
      if (sqr <= sum) q = cand;
    end
    rem = sum - {64'd0, q} * {64'd0, q};
    if (rem > {64'd0, q}) q = q + 1;
    a.span = q[32:0];
    if (sum == 0) begin
      a.degen = 1'b1;
      return a;
    end
    if (op == OP_HEADING) begin
      // Fold the angle into the first octant: dz < 0 starts a quarter turn on.
      if (dz >= 0) begin
        lo_part = 64'(dz);
        hi_part = mx;
        m = 0;
      end else begin
        lo_part = mx;
        hi_part = mz;
        m = 64'(HALF_PI_ANG);
      end
      if (hi_part > lo_part) part = 64'(HALF_PI_ANG) - rotate_angle(hi_part, lo_part);
      else part = rotate_angle(lo_part, hi_part);
      m = m + part;
      h = (dx > 0) ? 64'(ORIGIN_ANG) + m : 64'(ORIGIN_ANG) - m;
      h = (h + (64'd1 << 31)) >> 32;
      a.head = h[23:0];
    end
    return a;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  // A result passes the whole pipeline after acceptance, so the check and the push
  // of the same edge never touch the same entry.
  always @(posedge clk) begin
    answer_t want;
    if (!rst && done) begin
      answers_seen++;
      if (pending_answers.size() == 0) begin
        report_mismatch("unexpected result, distance", distance, 0);
      end else begin
        want = pending_answers.pop_front();
        if (distance !== want.span) report_mismatch("distance", distance, want.span);
        if (heading !== want.head) report_mismatch("heading", heading, want.head);
        if (degenerate !== want.degen) report_mismatch("degenerate", degenerate, want.degen);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_answers.size());
      $display("tb_point_distance_and_heading: done, errors");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] op, input logic signed [31:0] px,
      input logic signed [31:0] py, input logic signed [31:0] pz,
      input logic signed [31:0] tx, input logic signed [31:0] ty,
      input logic signed [31:0] tz);
    @(negedge clk);
    start = 1'b1;
    opcode = op;
    pos_x = px; pos_y = py; pos_z = pz;
    tar_x = tx; tar_y = ty; tar_z = tz;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_answers.push_back(predict_answer(op, px, py, pz, tx, ty, tz));
    items_sent++;
  endtask

  // Ends the current burst now and then at random with a gap of junk inputs.
  task automatic maybe_pause();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 20);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    if (gap == 0) return;
    @(negedge clk);
    start = 1'b0;
    opcode = $urandom;
    pos_x = $urandom; tar_x = $urandom;
    repeat (gap - 1) @(negedge clk);
  endtask

  task automatic drain_results();
    @(negedge clk);
    start = 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  task automatic test_extremes();
    logic signed [31:0] lo, hi;
    lo = 32'sh8000_0000;
    hi = 32'sh7fff_ffff;
    for (int op = 0; op < 4; op++) begin
      send_item(2'(op), lo, lo, lo, hi, hi, hi);
      send_item(2'(op), hi, lo, hi, lo, hi, lo);
      send_item(2'(op), lo, hi, hi, hi, lo, lo);
    end
  endtask

  task automatic test_special_cases();
    // Coincident points for each operation.
    for (int op = 0; op < 3; op++) send_item(2'(op), 32'sd1000, 32'sd5, -32'sd7,
                                             32'sd1000, 32'sd5, -32'sd7);
    // Axis and diagonal headings: with zero dx the heading falls at or below the origin, dz < 0 gives the bottom value.
    send_item(OP_HEADING, 0, 0, 32'sd65536, 0, 0, 0);
    send_item(OP_HEADING, 0, 0, 0, 0, 0, 32'sd65536);
    send_item(OP_HEADING, 0, 0, 0, 32'sd65536, 0, 0);
    send_item(OP_HEADING, 0, 0, 0, -32'sd65536, 0, 0);
    send_item(OP_HEADING, 0, 0, 0, 32'sd3, 0, -32'sd3);
    // Only y differs: planar sees coincident points, spatial does not.
    send_item(OP_PLANAR, 0, 32'sd9, 0, 0, -32'sd9, 0);
    send_item(OP_SPATIAL, 0, 32'sd9, 0, 0, -32'sd9, 0);
  endtask

  function automatic logic signed [31:0] near_value(input logic signed [31:0] base);
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return base;
      2: return base + $signed(32'($urandom_range(0, 512)) - 32'sd256);
      default: return base + ($signed($urandom) >>> $urandom_range(4, 30));
    endcase
  endfunction

  task automatic test_random(input int count);
    logic [1:0]         op;
    logic signed [31:0] px, py, pz;
    for (int n = 0; n < count; n++) begin
      op = ($urandom_range(0, 15) == 0) ? 2'(OP_NONE) : 2'($urandom_range(0, 2));
      px = $urandom;
      py = $urandom;
      pz = $urandom;
      send_item(op, px, py, pz, near_value(px), near_value(py), near_value(pz));
      maybe_pause();
      if (n == count / 2) drain_results();
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    opcode = '0;
    pos_x = '0; pos_y = '0; pos_z = '0;
    tar_x = '0; tar_y = '0; tar_z = '0;
    error_count = 0;
    items_sent = 0;
    answers_seen = 0;
    burst_left = 0;
    cycle_count = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_extremes();
    test_special_cases();
    drain_results();
    test_random(380);
    drain_results();
    repeat (LATENCY + 10) @(posedge clk);
    $display("Sent %0d items over all opcodes, extremes and coincident points;", items_sent);
    $display("checked %0d results against the predicted distance and heading.", answers_seen);
    if (error_count == 0) begin
      $display("tb_point_distance_and_heading: done, clean");
    end else begin
      $display("tb_point_distance_and_heading: done, errors");
    end
    $finish;
  end

endmodule

// ===== point_distance_and_heading.f =====
src/pdh_pkg.sv
src/pdh_front.sv
src/pdh_sqrt.sv
src/pdh_angle.sv
src/point_distance_and_heading.sv
sim/tb_point_distance_and_heading.sv
